### design/tfb_pkg.sv
// Shared types and constants for the telemetry frame builder.
// No dependencies; imported by every design module.
`default_nettype none

package tfb_pkg;

    // Frame layout
    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam int         HEADER_BYTES  = 4;
    localparam int         CHECK_BYTES   = 2;
    localparam int         FRAME_BUFFER_BYTES_DEFAULT = 256;
    // Wide enough for header + 255 payload + check bytes and the buffer size
    localparam int         SIZE_W        = 10;

    // Command queue between front and back
    localparam int         QUEUE_DEPTH   = 4;
    localparam int         QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Input op codes
    localparam logic       OP_START      = 1'b0;
    localparam logic       OP_PAYLOAD    = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] dest_address;
        logic [7:0] message_id;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
        logic       length_error;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_PAYLOAD,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] dest_address;
        logic [7:0] message_id;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
        logic       last;           // payload: final byte of the frame
    } cmd_t;

    typedef enum logic [2:0] {
        STEP_SYNC,
        STEP_ADDR,
        STEP_ID,
        STEP_LEN,
        STEP_DATA,
        STEP_SUM,
        STEP_SOS,
        STEP_ERR
    } emit_step_t;

endpackage

`default_nettype wire

### design/tfb_front.sv
// Front end: accepts input requests, tracks the open frame, issues commands.
// Depends on tfb_pkg.
`default_nettype none

module tfb_front #(
    parameter int FRAME_BUFFER_BYTES = tfb_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tfb_pkg::in_item_t in_item,
    output logic                  cmd_push,
    output tfb_pkg::cmd_t         cmd_data,
    input  wire logic             queue_full
);
    import tfb_pkg::*;

    localparam logic [SIZE_W-1:0] LIMIT = SIZE_W'(FRAME_BUFFER_BYTES);
    localparam logic [SIZE_W-1:0] OVERHEAD = SIZE_W'(HEADER_BYTES + CHECK_BYTES);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] remaining_reg, remaining_next;
    logic       accept;
    logic       too_long;
    logic       last_byte;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign too_long  = (OVERHEAD + {{(SIZE_W-8){1'b0}}, in_item.payload_length}) > LIMIT;
    assign last_byte = (remaining_reg == 8'd1);

    always_comb
    begin
        frame_open_next          = frame_open_reg;
        remaining_next           = remaining_reg;
        cmd_push                 = 1'b0;
        cmd_data.kind            = CMD_START;
        cmd_data.dest_address    = in_item.dest_address;
        cmd_data.message_id      = in_item.message_id;
        cmd_data.payload_length  = in_item.payload_length;
        cmd_data.payload_byte    = in_item.payload_byte;
        cmd_data.last            = last_byte;
        if (accept)
        begin
            if (in_item.op == OP_START)
            begin
                // A new start always abandons any open frame.
                cmd_push = 1'b1;
                if (too_long)
                begin
                    cmd_data.kind   = CMD_ERROR;
                    frame_open_next = 1'b0;
                    remaining_next  = 8'd0;
                end
                else
                begin
                    frame_open_next = (in_item.payload_length != 8'd0);
                    remaining_next  = in_item.payload_length;
                end
            end
            else if (frame_open_reg)
            begin
                cmd_push       = 1'b1;
                cmd_data.kind  = CMD_PAYLOAD;
                remaining_next = remaining_reg - 8'd1;
                if (last_byte)
                begin
                    frame_open_next = 1'b0;
                end
            end
            // payload with no open frame: dropped silently
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= 8'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
        end
    end

endmodule

`default_nettype wire

### design/tfb_queue.sv
// Small command FIFO between the front end and the byte emitter.
// Depends on tfb_pkg.
`default_nettype none

module tfb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tfb_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output tfb_pkg::cmd_t      pop_data,
    output logic               not_empty
);
    import tfb_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/tfb_back.sv
// Back end: expands commands into frame bytes, keeps the check sums,
// and holds the output register. Depends on tfb_pkg.
`default_nettype none

module tfb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_avail,
    input  wire tfb_pkg::cmd_t cmd_data,
    output logic               cmd_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tfb_pkg::out_item_t out_item
);
    import tfb_pkg::*;

    cmd_t       cmd_reg;
    logic       busy_reg;
    emit_step_t step_reg, step_next;
    logic       step_done;
    logic [7:0] sum_reg, sos_reg;
    out_item_t  out_reg;
    logic       out_valid_reg;

    logic       load_out;
    logic       fire;
    out_item_t  emit_item;
    logic       summed;
    logic       restart_sums;
    logic [7:0] sum_base, sos_base, sum_new, sos_new;

    assign load_out = !out_valid_reg || out_ready;
    assign fire     = busy_reg && load_out;
    assign cmd_pop  = cmd_avail && (!busy_reg || (fire && step_done));

    // Next step of the byte sequence
    always_comb
    begin
        step_next = step_reg;
        step_done = 1'b0;
        case (step_reg)
            STEP_SYNC: step_next = STEP_ADDR;
            STEP_ADDR: step_next = STEP_ID;
            STEP_ID:   step_next = STEP_LEN;
            STEP_LEN:
            begin
                if (cmd_reg.payload_length == 8'd0)
                begin
                    step_next = STEP_SUM;
                end
                else
                begin
                    step_done = 1'b1;
                end
            end
            STEP_DATA:
            begin
                if (cmd_reg.last)
                begin
                    step_next = STEP_SUM;
                end
                else
                begin
                    step_done = 1'b1;
                end
            end
            STEP_SUM:  step_next = STEP_SOS;
            STEP_SOS:  step_done = 1'b1;
            STEP_ERR:  step_done = 1'b1;
            default:   step_done = 1'b1;
        endcase
    end

    // Byte produced at the current step
    always_comb
    begin
        emit_item    = '0;
        summed       = 1'b0;
        restart_sums = 1'b0;
        case (step_reg)
            STEP_SYNC:
            begin
                emit_item.out_byte = SYNC_BYTE;
                summed             = 1'b1;
                restart_sums       = 1'b1;
            end
            STEP_ADDR:
            begin
                emit_item.out_byte = cmd_reg.dest_address;
                summed             = 1'b1;
            end
            STEP_ID:
            begin
                emit_item.out_byte = cmd_reg.message_id;
                summed             = 1'b1;
            end
            STEP_LEN:
            begin
                emit_item.out_byte = cmd_reg.payload_length;
                summed             = 1'b1;
            end
            STEP_DATA:
            begin
                emit_item.out_byte = cmd_reg.payload_byte;
                summed             = 1'b1;
            end
            STEP_SUM:
            begin
                emit_item.out_byte = sum_reg;
            end
            STEP_SOS:
            begin
                emit_item.out_byte     = sos_reg;
                emit_item.end_of_frame = 1'b1;
            end
            STEP_ERR:
            begin
                emit_item.end_of_frame = 1'b1;
                emit_item.length_error = 1'b1;
            end
            default:
            begin
                emit_item = '0;
            end
        endcase
    end

    assign sum_base = restart_sums ? 8'd0 : sum_reg;
    assign sos_base = restart_sums ? 8'd0 : sos_reg;
    assign sum_new  = sum_base + emit_item.out_byte;
    assign sos_new  = sos_base + sum_new;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        if (fire && summed)
        begin
            sum_reg <= sum_new;
            sos_reg <= sos_new;
        end
        if (load_out && fire)
        begin
            out_reg <= emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                busy_reg <= 1'b1;
                case (cmd_data.kind)
                    CMD_START:   step_reg <= STEP_SYNC;
                    CMD_PAYLOAD: step_reg <= STEP_DATA;
                    CMD_ERROR:   step_reg <= STEP_ERR;
                    default:     step_reg <= STEP_ERR;
                endcase
            end
            else if (fire && step_done)
            begin
                busy_reg <= 1'b0;
            end
            else if (fire)
            begin
                step_reg <= step_next;
            end
            if (load_out)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

### design/telemetry_frame_builder_sum_add_check_top.sv
// Telemetry frame builder with sum / sum-of-sums check bytes.
// A request passes the queue and the emitter's command register before its first byte is
// registered for output. Throughput: one byte per cycle while out_ready is high, set by the
//   single output register; payloads give 1 byte (3 if last), starts 4 (6 with no payload).
// A 4-entry command queue absorbs header and check-byte bursts on the input side.
// Reset: rst_n asynchronous, active low; clears frame state, queue and output valid.
`default_nettype none

module telemetry_frame_builder_sum_add_check_top #(
    parameter int FRAME_BUFFER_BYTES = tfb_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tfb_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tfb_pkg::out_item_t     out_item
);
    import tfb_pkg::*;

    // Front end -> queue
    logic cmd_push;
    cmd_t cmd_in;
    logic queue_full;

    // Queue -> back end
    cmd_t cmd_out;
    logic cmd_avail;
    logic cmd_pop;

    // Front end decides frame open/close and length errors per request,
    // so the emitter never has to look ahead.
    tfb_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in),
        .queue_full (queue_full)
    );

    // Decouples input acceptance from output back-pressure.
    tfb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .not_empty (cmd_avail)
    );

    // Expands each command into 1..6 bytes and maintains the running sums.
    tfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
